[hw/rtl/wpe_pkg.sv]
// wpe_pkg: shared widths, register indexes, cell control types and the
// small reciprocal divide used by the window pooling engine.
// No dependencies; used by wpe_cell, wpe_div and window_pooling_engine.
package wpe_pkg;

	// field widths
	localparam int PIX_W      = 16;
	localparam int IDX_W      = 22;
	localparam int MODE_W     = 2;
	localparam int POOL_W     = 4;
	localparam int STRIDE_W   = 4;
	localparam int HEIGHT_W   = 9;
	localparam int WIDTH_W    = 9;
	localparam int CHAN_W     = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int OUT_DATA_W = ((PIX_W + IDX_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 2;

	// parameter defaults
	localparam int DEF_MAX_POOL     = 8;
	localparam int DEF_MAX_WIDTH    = 256;
	localparam int DEF_MAX_HEIGHT   = 256;
	localparam int DEF_MAX_CHANNELS = 64;

	// widths sized for the whole parameter range (pool up to 16, dims up to 4096)
	localparam int P_W       = 5;
	localparam int SEL_W     = 4;
	localparam int SUM_W     = PIX_W + 2 * SEL_W + 1;
	localparam int DIM_W     = 13;
	localparam int REC_W     = 18;
	localparam int REC_SHIFT = 17;
	localparam int DIVISOR_W = 2 * P_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CHANS  = 3'd5;

	// pooling kinds; the spare code also averages
	localparam logic [MODE_W-1:0] MODE_MAX     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MIN     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AVG     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_AVG_ALT = 2'd3;

	// controls common to all cells
	typedef struct packed {
		logic             rd_en;
		logic             acc_en;
		logic             acc_first;
		logic [SEL_W-1:0] acc_col;
		logic             find_max;
	} cell_ctl_t;

	// per-cell role in the current window
	typedef struct packed {
		logic             en;
		logic             first;
		logic [SEL_W-1:0] row_i;
	} cell_sel_t;

	// running result handed around the ring
	typedef struct packed {
		logic signed [PIX_W-1:0] val;
		logic signed [SUM_W-1:0] sum;
		logic [SEL_W-1:0]        row_i;
		logic [SEL_W-1:0]        col_j;
	} carry_t;

	// ceil(2^REC_SHIFT / s) for s in 1..16
	function automatic logic [REC_W-1:0] recip(input logic [P_W-1:0] s);
		logic [REC_W-1:0] r;
		case (s)
			5'd1:    r = 18'd131072;
			5'd2:    r = 18'd65536;
			5'd3:    r = 18'd43691;
			5'd4:    r = 18'd32768;
			5'd5:    r = 18'd26215;
			5'd6:    r = 18'd21846;
			5'd7:    r = 18'd18725;
			5'd8:    r = 18'd16384;
			5'd9:    r = 18'd14564;
			5'd10:   r = 18'd13108;
			5'd11:   r = 18'd11916;
			5'd12:   r = 18'd10923;
			5'd13:   r = 18'd10083;
			5'd14:   r = 18'd9363;
			5'd15:   r = 18'd8739;
			5'd16:   r = 18'd8192;
			default: r = '0;
		endcase
		return r;
	endfunction

	// floor(r / s), exact for r < 8192 and s in 1..16
	function automatic logic [DIM_W-1:0] div_small(input logic [DIM_W-1:0] r,
		input logic [P_W-1:0] s);
		logic [DIM_W+REC_W-1:0] prod;
		prod = {{REC_W{1'b0}}, r} * {{DIM_W{1'b0}}, recip(s)};
		return prod[REC_SHIFT +: DIM_W];
	endfunction

endpackage

[hw/rtl/wpe_cell.sv]
// wpe_cell: one row bank of the window pooling engine. Holds one row of the
// store, reduces its window row over the column scan, and merges into the ring.
// Depends on wpe_pkg.
module wpe_cell #(
	parameter int MAX_WIDTH = wpe_pkg::DEF_MAX_WIDTH
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]      wr_addr,
	input  logic signed [wpe_pkg::PIX_W-1:0]  wr_data,
	input  logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
	input  wpe_pkg::cell_ctl_t                ctl,
	input  wpe_pkg::cell_sel_t                sel,
	input  wpe_pkg::carry_t                   carry_in,
	output wpe_pkg::carry_t                   carry_out
);

	logic signed [wpe_pkg::PIX_W-1:0] mem [MAX_WIDTH];
	logic signed [wpe_pkg::PIX_W-1:0] rd_q;
	logic signed [wpe_pkg::PIX_W-1:0] own_best_q;
	logic [wpe_pkg::SEL_W-1:0]        own_col_q;
	logic signed [wpe_pkg::SUM_W-1:0] own_sum_q;
	logic signed [wpe_pkg::SUM_W-1:0] rd_ext;
	logic                             rd_wins;
	logic                             own_wins;
	wpe_pkg::carry_t                  merged;
	wpe_pkg::carry_t                  pass_q;

	// row bank, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_ext  = {{(wpe_pkg::SUM_W - wpe_pkg::PIX_W){rd_q[wpe_pkg::PIX_W-1]}}, rd_q};
	assign rd_wins = ctl.find_max ? (rd_q > own_best_q) : (rd_q < own_best_q);

	// per-row reduction, columns in order; strict compare keeps the first best
	always_ff @(posedge clk) begin
		if (ctl.acc_en) begin
			if (ctl.acc_first) begin
				own_best_q <= rd_q;
				own_col_q  <= ctl.acc_col;
				own_sum_q  <= rd_ext;
			end else begin
				if (rd_wins) begin
					own_best_q <= rd_q;
					own_col_q  <= ctl.acc_col;
				end
				own_sum_q <= own_sum_q + rd_ext;
			end
		end
	end

	// merge with the rows above; earlier rows win ties
	assign own_wins = ctl.find_max ? (own_best_q > carry_in.val) : (own_best_q < carry_in.val);

	always_comb begin
		merged = carry_in;
		if (sel.first) begin
			merged.val   = own_best_q;
			merged.sum   = own_sum_q;
			merged.row_i = sel.row_i;
			merged.col_j = own_col_q;
		end else if (sel.en) begin
			merged.sum = carry_in.sum + own_sum_q;
			if (own_wins) begin
				merged.val   = own_best_q;
				merged.row_i = sel.row_i;
				merged.col_j = own_col_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		pass_q <= merged;
	end

	assign carry_out = pass_q;

endmodule

[hw/rtl/wpe_div.sv]
// wpe_div: signed window sum divided by the window area, truncating toward
// zero; restoring division, one quotient bit per cycle. Depends on wpe_pkg.
module wpe_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [wpe_pkg::SUM_W-1:0]    dividend,
	input  logic [wpe_pkg::DIVISOR_W-1:0]       divisor,
	output logic signed [wpe_pkg::PIX_W-1:0]    quotient,
	output logic                                done
);

	localparam int SW    = wpe_pkg::SUM_W;
	localparam int DV    = wpe_pkg::DIVISOR_W;
	localparam int CNT_W = $clog2(SW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]    mag_q;
	logic [SW-1:0]    quo_q;
	logic [DV-1:0]    rem_q;
	logic [DV-1:0]    div_q;
	logic             neg_q;
	logic [DV-1:0]    trial;
	logic             take;
	logic [SW-1:0]    signed_quo;

	assign trial = {rem_q[DV-2:0], mag_q[SW-1]};
	assign take  = trial >= div_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(SW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SW-1];
			mag_q <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[SW-2:0], 1'b0};
			quo_q <= {quo_q[SW-2:0], take};
			rem_q <= take ? (trial - div_q) : trial;
		end
	end

	assign signed_quo = neg_q ? (~quo_q + SW'(1)) : quo_q;
	assign quotient   = signed_quo[wpe_pkg::PIX_W-1:0];
	assign done       = done_q;

endmodule

[hw/rtl/window_pooling_engine.sv]
// window_pooling_engine: 2-D max / min / average pooling over a streamed
// feature map, a ring of row-bank cells plus a serial divider.
// Depends on wpe_pkg, wpe_cell, wpe_div.
//
//  channel | signals                              | beat carries
//  --------+--------------------------------------+-------------------------------
//  s_      | s_tvalid s_tready s_tdata[15:0]      | pixel_value
//  m_      | m_tvalid m_tready m_tdata m_tlast    | pooled_value, source_index,
//          | m_tuser[1:0]                         | frame_last, index_valid, error
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// A closing window reads one bank per window column, then hops the ring through
// all MAX_POOL cells to merge the rows; average then waits for the serial divider.
// Reset clears the counters, control state and configuration registers; the row
// banks and datapath registers are not cleared.
// A stalled output holds the result; the next pixel is still taken, and its
// own result waits in the finish state until the output register is free.
module window_pooling_engine #(
	parameter int MAX_POOL     = wpe_pkg::DEF_MAX_POOL,
	parameter int MAX_WIDTH    = wpe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = wpe_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = wpe_pkg::DEF_MAX_CHANNELS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [wpe_pkg::PIX_W-1:0]             s_tdata,   // [15:0] pixel_value
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [wpe_pkg::OUT_DATA_W-1:0]        m_tdata,   // [15:0] pooled_value,
	                                                         // [37:16] source_index
	output logic                                  m_tlast,   // frame_last
	output logic [wpe_pkg::OUT_USER_W-1:0]        m_tuser,   // [0] index_valid,
	                                                         // [1] config_error
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [wpe_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wpe_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int DW     = wpe_pkg::DIM_W;
	localparam int PW     = wpe_pkg::P_W;
	localparam int SW     = wpe_pkg::SEL_W;
	localparam int IW     = wpe_pkg::IDX_W;
	localparam int XW     = wpe_pkg::PIX_W;
	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int SLOT_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
	localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
	localparam int RING_W = $clog2(MAX_POOL + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EV1   = 4'd1;
	localparam logic [3:0] S_EV2   = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_DRAIN = 4'd4;
	localparam logic [3:0] S_RING  = 4'd5;
	localparam logic [3:0] S_IDX1  = 4'd6;
	localparam logic [3:0] S_IDX2  = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	// configuration registers
	logic [wpe_pkg::MODE_W-1:0]   reg_mode_q;
	logic [wpe_pkg::POOL_W-1:0]   reg_pool_q;
	logic [wpe_pkg::STRIDE_W-1:0] reg_stride_q;
	logic [wpe_pkg::HEIGHT_W-1:0] reg_height_q;
	logic [wpe_pkg::WIDTH_W-1:0]  reg_width_q;
	logic [wpe_pkg::CHAN_W-1:0]   reg_chans_q;

	logic [PW-1:0]   p_c;
	logic [PW-1:0]   s_c;
	logic [DW-1:0]   h_c;
	logic [DW-1:0]   w_c;
	logic [CH_W-1:0] c_c;
	logic [DW-1:0]   p_ext;
	logic            use_avg;

	// position counters
	logic [3:0]        state_q;
	logic [DW-1:0]     col_q;
	logic [DW-1:0]     row_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CH_W-1:0]   ch_q;
	logic [DW-1:0]     col_use;
	logic [DW-1:0]     row_use;
	logic [SLOT_W-1:0] slot_use;
	logic [CH_W-1:0]   ch_use;
	logic              accept;

	// current pixel
	logic [DW-1:0]     cur_row_q;
	logic [DW-1:0]     cur_col_q;
	logic [SLOT_W-1:0] cur_slot_q;
	logic [CH_W-1:0]   cur_ch_q;

	// window evaluation
	logic          row_hit_q;
	logic          col_hit_q;
	logic          fits_q;
	logic          frame_end_q;
	logic [DW-1:0] rp_q;
	logic [DW-1:0] cp_q;
	logic [DW-1:0] qr_q;
	logic [DW-1:0] qc_q;
	logic [DW-1:0] qoh_q;
	logic [DW-1:0] qow_q;
	logic [DW+PW-1:0] mr;
	logic [DW+PW-1:0] mc;
	logic          win_hit;
	logic          win_last;

	// scan and ring
	logic [SLOT_W-1:0] st_q;
	logic [SLOT_W-1:0] end_q;
	logic [SLOT_W-1:0] st_nx;
	logic [SLOT_W-1:0] end_nx;
	logic [SW-1:0]     j_q;
	logic [RING_W-1:0] ring_q;
	logic              acc_en_q;
	logic              acc_first_q;
	logic [SW-1:0]     acc_col_q;
	logic              last_q;

	wpe_pkg::cell_ctl_t ctl;
	wpe_pkg::cell_sel_t sel   [MAX_POOL];
	wpe_pkg::carry_t    carry [MAX_POOL];
	wpe_pkg::carry_t    fin;
	logic [MAX_POOL-1:0] wr_vec;
	logic [CW-1:0]       rd_addr;
	logic [DW-1:0]       rd_col;

	// index arithmetic
	logic [IW-1:0]      hw_q;
	logic [IW-1:0]      chb_q;
	logic [IW-1:0]      rw_q;
	logic [DW-1:0]      bc_q;
	logic [2*DW-1:0]    hw_prod;
	logic [CH_W+IW-1:0] chb_prod;
	logic [2*DW-1:0]    rw_prod;
	logic [DW-1:0]      br;

	// result
	logic signed [XW-1:0] res_val_q;
	logic [IW-1:0]        res_idx_q;
	logic                 res_iv_q;
	logic                 res_last_q;
	logic                 res_err_q;
	logic                 use_div_q;
	logic                 out_free;

	logic                 div_start;
	logic signed [XW-1:0] div_quo;
	logic                 div_done;
	logic [wpe_pkg::DIVISOR_W-1:0] div_den;

	logic                 m_tvalid_q;
	logic [XW-1:0]        m_val_q;
	logic [IW-1:0]        m_idx_q;
	logic                 m_last_q;
	logic                 m_iv_q;
	logic                 m_err_q;

	// register writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_mode_q   <= wpe_pkg::MODE_MAX;
			reg_pool_q   <= 4'd2;
			reg_stride_q <= 4'd2;
			reg_height_q <= 9'd256;
			reg_width_q  <= 9'd256;
			reg_chans_q  <= 7'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				wpe_pkg::REG_MODE:   reg_mode_q   <= cfg_data[wpe_pkg::MODE_W-1:0];
				wpe_pkg::REG_POOL:   reg_pool_q   <= cfg_data[wpe_pkg::POOL_W-1:0];
				wpe_pkg::REG_STRIDE: reg_stride_q <= cfg_data[wpe_pkg::STRIDE_W-1:0];
				wpe_pkg::REG_HEIGHT: reg_height_q <= cfg_data[wpe_pkg::HEIGHT_W-1:0];
				wpe_pkg::REG_WIDTH:  reg_width_q  <= cfg_data[wpe_pkg::WIDTH_W-1:0];
				wpe_pkg::REG_CHANS:  reg_chans_q  <= cfg_data[wpe_pkg::CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp registers to their usable ranges
	always_comb begin
		if (reg_pool_q == '0) p_c = PW'(1);
		else if (int'(reg_pool_q) > MAX_POOL) p_c = PW'(MAX_POOL);
		else p_c = PW'(reg_pool_q);
		if (reg_stride_q == '0) s_c = PW'(1);
		else if (int'(reg_stride_q) > MAX_POOL) s_c = PW'(MAX_POOL);
		else s_c = PW'(reg_stride_q);
		if (reg_height_q == '0) h_c = DW'(1);
		else if (int'(reg_height_q) > MAX_HEIGHT) h_c = DW'(MAX_HEIGHT);
		else h_c = DW'(reg_height_q);
		if (reg_width_q == '0) w_c = DW'(1);
		else if (int'(reg_width_q) > MAX_WIDTH) w_c = DW'(MAX_WIDTH);
		else w_c = DW'(reg_width_q);
		if (reg_chans_q == '0) c_c = CH_W'(1);
		else if (int'(reg_chans_q) > MAX_CHANNELS) c_c = CH_W'(MAX_CHANNELS);
		else c_c = CH_W'(reg_chans_q);
	end

	assign p_ext   = DW'(p_c);
	assign use_avg = !(reg_mode_q == wpe_pkg::MODE_MAX || reg_mode_q == wpe_pkg::MODE_MIN);

	// counters past a shrunk size restart at zero
	always_comb begin
		col_use  = (col_q >= w_c) ? '0 : col_q;
		row_use  = (row_q >= h_c) ? '0 : row_q;
		slot_use = (row_q >= h_c) ? '0 : slot_q;
		ch_use   = (ch_q >= c_c) ? '0 : ch_q;
	end

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// window test arithmetic
	assign mr       = {{PW{1'b0}}, qr_q} * {{DW{1'b0}}, s_c};
	assign mc       = {{PW{1'b0}}, qc_q} * {{DW{1'b0}}, s_c};
	assign win_hit  = fits_q && row_hit_q && col_hit_q &&
		(rp_q == mr[DW-1:0]) && (cp_q == mc[DW-1:0]);
	assign win_last = (cur_ch_q == c_c - CH_W'(1)) && (qr_q == qoh_q) && (qc_q == qow_q);

	// first and last bank of the window rows
	always_comb begin
		int st_i;
		int end_i;
		if (int'(cur_slot_q) >= int'(p_c) - 1) st_i = int'(cur_slot_q) - int'(p_c) + 1;
		else st_i = int'(cur_slot_q) + MAX_POOL - int'(p_c) + 1;
		end_i = st_i + int'(p_c) - 1;
		if (end_i >= MAX_POOL) end_i = end_i - MAX_POOL;
		st_nx  = SLOT_W'(st_i);
		end_nx = SLOT_W'(end_i);
	end

	// multiplier inputs for the flat index
	assign hw_prod  = {{DW{1'b0}}, h_c} * {{DW{1'b0}}, w_c};
	assign chb_prod = {{IW{1'b0}}, cur_ch_q} * {{CH_W{1'b0}}, hw_q};
	assign br       = rp_q + DW'(fin.row_i);
	assign rw_prod  = {{DW{1'b0}}, br} * {{DW{1'b0}}, w_c};
	assign fin      = carry[end_q];
	assign out_free = !m_tvalid_q || m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			slot_q      <= '0;
			ch_q        <= '0;
			j_q         <= '0;
			ring_q      <= '0;
			acc_en_q    <= 1'b0;
			acc_first_q <= 1'b0;
			acc_col_q   <= '0;
			use_div_q   <= 1'b0;
		end else begin
			acc_en_q    <= (state_q == S_SCAN);
			acc_first_q <= (j_q == '0);
			acc_col_q   <= j_q;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EV1;
						if (col_use + DW'(1) >= w_c) begin
							col_q <= '0;
							if (row_use + DW'(1) >= h_c) begin
								row_q  <= '0;
								slot_q <= '0;
								ch_q   <= (ch_use + CH_W'(1) >= c_c) ? '0 : ch_use + CH_W'(1);
							end else begin
								row_q  <= row_use + DW'(1);
								slot_q <= (slot_use == SLOT_W'(MAX_POOL - 1)) ? '0 :
									slot_use + SLOT_W'(1);
								ch_q   <= ch_use;
							end
						end else begin
							col_q  <= col_use + DW'(1);
							row_q  <= row_use;
							slot_q <= slot_use;
							ch_q   <= ch_use;
						end
					end
				end
				S_EV1: begin
					state_q <= S_EV2;
				end
				S_EV2: begin
					j_q <= '0;
					if (!fits_q) begin
						use_div_q <= 1'b0;
						state_q   <= frame_end_q ? S_FIN : S_IDLE;
					end else if (win_hit) begin
						use_div_q <= use_avg;
						state_q   <= S_SCAN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					j_q <= j_q + SW'(1);
					if (j_q == SW'(p_c - PW'(1))) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					ring_q  <= '0;
					state_q <= S_RING;
				end
				S_RING: begin
					ring_q <= ring_q + RING_W'(1);
					if (ring_q == RING_W'(MAX_POOL - 1)) begin
						state_q <= S_IDX1;
					end
				end
				S_IDX1: begin
					state_q <= S_IDX2;
				end
				S_IDX2: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free && (!use_div_q || div_done)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_row_q  <= row_use;
			cur_col_q  <= col_use;
			cur_slot_q <= slot_use;
			cur_ch_q   <= ch_use;
		end
		if (state_q == S_EV1) begin
			row_hit_q   <= cur_row_q + DW'(1) >= p_ext;
			col_hit_q   <= cur_col_q + DW'(1) >= p_ext;
			fits_q      <= (p_ext <= h_c) && (p_ext <= w_c);
			frame_end_q <= (cur_ch_q == c_c - CH_W'(1)) && (cur_row_q == h_c - DW'(1)) &&
				(cur_col_q == w_c - DW'(1));
			rp_q  <= cur_row_q + DW'(1) - p_ext;
			cp_q  <= cur_col_q + DW'(1) - p_ext;
			qr_q  <= wpe_pkg::div_small(cur_row_q + DW'(1) - p_ext, s_c);
			qc_q  <= wpe_pkg::div_small(cur_col_q + DW'(1) - p_ext, s_c);
			qoh_q <= wpe_pkg::div_small(h_c - p_ext, s_c);
			qow_q <= wpe_pkg::div_small(w_c - p_ext, s_c);
		end
		if (state_q == S_EV2) begin
			st_q       <= st_nx;
			end_q      <= end_nx;
			last_q     <= win_last;
			hw_q       <= hw_prod[IW-1:0];
			res_val_q  <= '0;
			res_idx_q  <= '0;
			res_iv_q   <= 1'b0;
			res_last_q <= 1'b1;
			res_err_q  <= 1'b1;
		end
		if (state_q == S_SCAN) begin
			chb_q <= chb_prod[IW-1:0];
		end
		if (state_q == S_IDX1) begin
			rw_q      <= rw_prod[IW-1:0];
			bc_q      <= cp_q + DW'(fin.col_j);
			res_val_q <= fin.val;
			res_iv_q  <= !use_div_q;
			res_last_q <= last_q;
			res_err_q <= 1'b0;
		end
		if (state_q == S_IDX2) begin
			res_idx_q <= use_div_q ? '0 : (chb_q + rw_q + IW'(bc_q));
		end
	end

	// cell controls
	assign rd_col = cp_q + DW'(j_q);
	assign rd_addr = rd_col[CW-1:0];

	always_comb begin
		ctl.rd_en     = (state_q == S_SCAN);
		ctl.acc_en    = acc_en_q;
		ctl.acc_first = acc_first_q;
		ctl.acc_col   = acc_col_q;
		ctl.find_max  = (reg_mode_q == wpe_pkg::MODE_MAX);
	end

	// ring of row banks
	for (genvar k = 0; k < MAX_POOL; k++) begin : g_cell
		always_comb begin
			int rel;
			if (k >= int'(st_q)) rel = k - int'(st_q);
			else rel = k + MAX_POOL - int'(st_q);
			sel[k].en    = rel < int'(p_c);
			sel[k].first = (k == int'(st_q));
			sel[k].row_i = SW'(rel);
			wr_vec[k]    = accept && (slot_use == SLOT_W'(k));
		end

		wpe_cell #(
			.MAX_WIDTH(MAX_WIDTH)
		) u_cell (
			.clk      (clk),
			.wr_en    (wr_vec[k]),
			.wr_addr  (col_use[CW-1:0]),
			.wr_data  (s_tdata),
			.rd_addr  (rd_addr),
			.ctl      (ctl),
			.sel      (sel[k]),
			.carry_in (carry[(k + MAX_POOL - 1) % MAX_POOL]),
			.carry_out(carry[k])
		);
	end

	// average divider
	assign div_start = (state_q == S_IDX1) && use_div_q;
	assign div_den   = {{PW{1'b0}}, p_c} * {{PW{1'b0}}, p_c};

	wpe_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(fin.sum),
		.divisor (div_den),
		.quotient(div_quo),
		.done    (div_done)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_FIN) && out_free && (!use_div_q || div_done)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free && (!use_div_q || div_done)) begin
			m_val_q  <= use_div_q ? div_quo : res_val_q;
			m_idx_q  <= res_idx_q;
			m_iv_q   <= res_iv_q;
			m_last_q <= res_last_q;
			m_err_q  <= res_err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(wpe_pkg::OUT_DATA_W - XW - IW){1'b0}}, m_idx_q, m_val_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = {m_err_q, m_iv_q};

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("pixel taken while previous one still in work");
	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0] && (m_tdata[37:0] == '0)))
		else $error("error result carries data");
	a_avg_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[37:16] == '0))
		else $error("index present without index_valid");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && use_div_q && !div_done) |=> (state_q == S_FIN))
		else $error("result left before the divider finished");
`endif

endmodule

[bench/window_pooling_engine_check.sv]
// window_pooling_engine_check: passive checker for the pooling engine. It
// watches the cfg, s_ and m_ channels, predicts every pooled result and compares.
// Depends on wpe_pkg for field widths, register indexes, mode codes and defaults.
module window_pooling_engine_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [wpe_pkg::PIX_W-1:0]       s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [wpe_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                            m_tlast,
	input  logic [wpe_pkg::OUT_USER_W-1:0]  m_tuser,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [wpe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wpe_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              fail_count,
	output int                              pending,
	output int                              checked
);

	localparam int NPOOL = wpe_pkg::DEF_MAX_POOL;
	localparam int NWID  = wpe_pkg::DEF_MAX_WIDTH;
	localparam int PW    = wpe_pkg::PIX_W;
	localparam int IW    = wpe_pkg::IDX_W;

	typedef struct packed {
		logic signed [PW-1:0] val;
		logic [IW-1:0]        idx;
		logic                 idx_ok;
		logic                 last;
		logic                 err;
	} pooled_t;

	pooled_t pooled_q[$];

	// shadow registers
	logic [wpe_pkg::MODE_W-1:0]   r_mode;
	logic [wpe_pkg::POOL_W-1:0]   r_pool;
	logic [wpe_pkg::STRIDE_W-1:0] r_stride;
	logic [wpe_pkg::HEIGHT_W-1:0] r_height;
	logic [wpe_pkg::WIDTH_W-1:0]  r_width;
	logic [wpe_pkg::CHAN_W-1:0]   r_chans;

	// shadow datapath state
	logic signed [PW-1:0] rows[0:NPOOL*NWID-1];
	int unsigned col_n, row_n, chan_n;

	function automatic int unsigned lim(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic signed [PW-1:0] store_at(int unsigned r, int unsigned c);
		return rows[(r % NPOOL) * NWID + c];
	endfunction

	// place one pixel and queue the window result it closes, if any
	function automatic void take_pixel(logic [PW-1:0] raw);
		int unsigned p, s, h, w, nc, r, c, ch, r0, c0, br, bc;
		int signed sum, v, best;
		logic closes, fits, fend, last;
		pooled_t res;
		p  = lim(r_pool, wpe_pkg::DEF_MAX_POOL);
		s  = lim(r_stride, wpe_pkg::DEF_MAX_POOL);
		h  = lim(r_height, wpe_pkg::DEF_MAX_HEIGHT);
		w  = lim(r_width, wpe_pkg::DEF_MAX_WIDTH);
		nc = lim(r_chans, wpe_pkg::DEF_MAX_CHANNELS);
		if (col_n >= w) col_n = 0;
		if (row_n >= h) row_n = 0;
		if (chan_n >= nc) chan_n = 0;
		r = row_n; c = col_n; ch = chan_n;
		rows[(r % NPOOL) * NWID + c] = raw;
		fits = (p <= h) && (p <= w);
		fend = (ch == nc - 1) && (r == h - 1) && (c == w - 1);
		closes = (r + 1 >= p) && (c + 1 >= p) && ((r + 1 - p) % s == 0)
			&& ((c + 1 - p) % s == 0);
		res = '0;
		if (!fits) begin
			if (fend) begin
				res.last = 1'b1;
				res.err  = 1'b1;
				pooled_q.push_back(res);
			end
		end else if (closes) begin
			r0 = r + 1 - p;
			c0 = c + 1 - p;
			last = (ch == nc - 1) && (r0 / s == (h - p) / s) && (c0 / s == (w - p) / s);
			res.last = last;
			if (r_mode != wpe_pkg::MODE_MAX && r_mode != wpe_pkg::MODE_MIN) begin
				sum = 0;
				for (int i = 0; i < p; i++)
					for (int j = 0; j < p; j++)
						sum += store_at(r0 + i, c0 + j);
				res.val = sum / int'(p * p);
			end else begin
				best = store_at(r0, c0);
				br = r0; bc = c0;
				for (int i = 0; i < p; i++)
					for (int j = 0; j < p; j++) begin
						v = store_at(r0 + i, c0 + j);
						if ((r_mode == wpe_pkg::MODE_MAX) ? (v > best) : (v < best)) begin
							best = v; br = r0 + i; bc = c0 + j;
						end
					end
				res.val    = best;
				res.idx    = ch * h * w + br * w + bc;
				res.idx_ok = 1'b1;
			end
			pooled_q.push_back(res);
		end
		col_n = c + 1;
		if (col_n >= w) begin
			col_n = 0;
			row_n = r + 1;
			if (row_n >= h) begin
				row_n = 0;
				chan_n = ch + 1;
				if (chan_n >= nc) chan_n = 0;
			end
		end
	endfunction

	assign pending = pooled_q.size();

	// observe all three channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		pooled_t want;
		if (!arst_n) begin
			r_mode = wpe_pkg::MODE_MAX; r_pool = 4'd2; r_stride = 4'd2;
			r_height = 9'd256; r_width = 9'd256; r_chans = 7'd1;
			col_n = 0; row_n = 0; chan_n = 0;
			fail_count <= 0;
			checked <= 0;
		end else begin
			if (s_tvalid && s_tready)
				take_pixel(s_tdata);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					wpe_pkg::REG_MODE:   r_mode   = cfg_data[wpe_pkg::MODE_W-1:0];
					wpe_pkg::REG_POOL:   r_pool   = cfg_data[wpe_pkg::POOL_W-1:0];
					wpe_pkg::REG_STRIDE: r_stride = cfg_data[wpe_pkg::STRIDE_W-1:0];
					wpe_pkg::REG_HEIGHT: r_height = cfg_data[wpe_pkg::HEIGHT_W-1:0];
					wpe_pkg::REG_WIDTH:  r_width  = cfg_data[wpe_pkg::WIDTH_W-1:0];
					wpe_pkg::REG_CHANS:  r_chans  = cfg_data[wpe_pkg::CHAN_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				checked <= checked + 1;
				if (pooled_q.size() == 0) begin
					$error("unexpected result beat, data %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = pooled_q.pop_front();
					if (m_tdata[PW-1:0] !== want.val || m_tdata[PW +: IW] !== want.idx
						|| m_tuser[0] !== want.idx_ok || m_tlast !== want.last
						|| m_tuser[1] !== want.err)
						fail_count <= fail_count + 1;
					if (m_tdata[PW-1:0] !== want.val)
						$error("pooled_value expected %0d actual %0d", want.val,
							$signed(m_tdata[PW-1:0]));
					if (m_tdata[PW +: IW] !== want.idx)
						$error("source_index expected %0d actual %0d", want.idx,
							m_tdata[PW +: IW]);
					if (m_tuser[0] !== want.idx_ok)
						$error("index_valid expected %0d actual %0d", want.idx_ok, m_tuser[0]);
					if (m_tlast !== want.last)
						$error("frame_last expected %0d actual %0d", want.last, m_tlast);
					if (m_tuser[1] !== want.err)
						$error("config_error expected %0d actual %0d", want.err, m_tuser[1]);
				end
			end
		end
	end
endmodule

[bench/window_pooling_engine_test.sv]
// window_pooling_engine_test: top of the pooling engine bench. Drives frames of
// pixels under many register settings, with random idling and one long output hold.
// Depends on wpe_pkg, window_pooling_engine and window_pooling_engine_check.
module window_pooling_engine_test;

	localparam int MD_MAX = int'(wpe_pkg::MODE_MAX);
	localparam int MD_MIN = int'(wpe_pkg::MODE_MIN);
	localparam int MD_AVG = int'(wpe_pkg::MODE_AVG);
	localparam int MD_ALT = int'(wpe_pkg::MODE_AVG_ALT);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [wpe_pkg::PIX_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [wpe_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic [wpe_pkg::OUT_USER_W-1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [wpe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [wpe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count, pending, checked;
	int pixels_sent = 0;
	int settings_used = 0;
	int hold_cycles = 0;
	bit quiet = 1'b0;

	always #5 clk = ~clk;

	window_pooling_engine dut (.*);

	window_pooling_engine_check check (.*);

	// output side: random stall bursts, plus one long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// run ends here if the engine hangs
	initial begin
		#30_000_000;
		$display("Verification failed");
		$finish;
	end

	// one pixel beat, with an optional idle burst before it
	task automatic push_pixel(logic [wpe_pkg::PIX_W-1:0] pix);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
		@(negedge clk);
	endtask

	// write all six registers once the engine has drained
	task automatic load_regs(int md, int ps, int st, int ht, int wd, int ch);
		int vals[6];
		logic [wpe_pkg::CFG_IDX_W-1:0] regs[6];
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		vals = '{md, ps, st, ht, wd, ch};
		regs = '{wpe_pkg::REG_MODE, wpe_pkg::REG_POOL, wpe_pkg::REG_STRIDE,
			wpe_pkg::REG_HEIGHT, wpe_pkg::REG_WIDTH, wpe_pkg::REG_CHANS};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i][wpe_pkg::CFG_DATA_W-1:0];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [wpe_pkg::PIX_W-1:0] make_pixel(int flavor);
		case (flavor)
			1: return wpe_pkg::PIX_W'($urandom_range(0, 4) - 2);
			2: case ($urandom_range(0, 3))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'hffff;
				default: return 16'h0000;
			endcase
			default: return wpe_pkg::PIX_W'($urandom);
		endcase
	endfunction

	// whole frames under the present settings
	task automatic send_frames(int ht, int wd, int ch, int frames, int flavor);
		repeat (frames * ht * wd * ch) push_pixel(make_pixel(flavor));
	endtask

	initial begin
		int md, ps, st, ht, wd, ch, fr;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extremes through a 1x1 max window
		load_regs(MD_MAX, 1, 1, 1, 4, 1);
		push_pixel(16'h7fff); push_pixel(16'h8000); push_pixel(16'h0000);
		push_pixel(16'hffff);
		// min with a tie: first pixel wins
		load_regs(MD_MIN, 2, 1, 2, 2, 1);
		repeat (4) push_pixel(16'h0005);
		// spare mode code averages; negative sums truncate toward zero
		load_regs(MD_ALT, 2, 2, 2, 2, 2);
		push_pixel(16'h8000); push_pixel(16'hffff); push_pixel(16'hffff);
		push_pixel(16'h0000); send_frames(1, 2, 2, 1, 2);
		// window larger than the input
		load_regs(MD_AVG, 3, 1, 2, 4, 1);
		send_frames(2, 4, 1, 1, 0);

		// out-of-range registers, clamped
		load_regs(MD_MAX, 15, 15, 8, 8, 1);
		send_frames(8, 8, 1, 1, 0);
		load_regs(MD_MIN, 0, 0, 0, 0, 0);
		send_frames(1, 1, 1, 2, 0);
		load_regs(MD_MIN, 1, 1, 1, 1, 127);
		send_frames(1, 1, 64, 1, 0);
		load_regs(MD_AVG, 1, 8, 1, 300, 1);
		send_frames(1, 256, 1, 1, 0);
		// every pixel a result: hold the output so the engine backs up
		load_regs(MD_MAX, 1, 1, 511, 1, 1);
		hold_cycles = 400;
		send_frames(256, 1, 1, 1, 0);

		// random settings over small frames
		while (pixels_sent < 1150) begin
			if (pixels_sent > 1000) quiet = 1'b1;
			md = $urandom_range(0, 3);
			ps = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : $urandom_range(1, 3);
			st = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : $urandom_range(1, 3);
			ht = $urandom_range(1, 10);
			wd = $urandom_range(1, 10);
			ch = $urandom_range(1, 3);
			fr = $urandom_range(1, 2);
			load_regs(md, ps, st, ht, wd, ch);
			send_frames(ht, wd, ch, fr, $urandom_range(0, 3) == 0 ? 1 : 0);
		end

		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("Sent %0d pixels under %0d register settings; %0d pooled results checked.",
			pixels_sent, settings_used, checked);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
